// File: design/bpfm_pkg.sv
// Shared types and constants for the buffer pool frame manager.
// No dependencies; the design files that use it refer to it by scoped names.
`default_nettype none

package bpfm_pkg;

   localparam int FRAMES_DEF = 16;
   localparam int PAGE_W     = 31;
   localparam int PIN_W      = 8;
   localparam logic [PIN_W-1:0] PIN_MAX = 8'd255;

   typedef enum logic [1:0] {
      KIND_PIN   = 2'd0,
      KIND_UNPIN = 2'd1,
      KIND_FREE  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_NO_CAND   = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_ZERO_PINS = 3'd3,
      STAT_PINNED    = 3'd4
   } status_type;

   // Frame cell update
   typedef enum logic [2:0] {
      FOP_HOLD    = 3'd0,
      FOP_FILL    = 3'd1,
      FOP_PIN_INC = 3'd2,
      FOP_UNPIN   = 3'd3,
      FOP_CLEAR   = 3'd4
   } frame_op_type;

   // List update
   typedef enum logic [1:0] {
      LOP_HOLD   = 2'd0,
      LOP_PUSH   = 2'd1,
      LOP_POP    = 2'd2,
      LOP_REMOVE = 2'd3
   } list_op_type;

   // Victim selection plan
   typedef enum logic [2:0] {
      PLAN_NONE  = 3'd0,
      PLAN_HIT   = 3'd1,
      PLAN_FREE  = 3'd2,
      PLAN_HATED = 3'd3,
      PLAN_LOVED = 3'd4
   } plan_type;

   typedef struct packed {
      logic              valid;
      logic [PAGE_W-1:0] page;
      logic [PIN_W-1:0]  pin;
      logic              dirty;
      logic              match;
   } frame_view_type;

endpackage

`default_nettype wire

// File: design/bpfm_frame_cell.sv
// One page frame: page id, valid, pin count and dirty mark, plus its tag match.
// Depends on bpfm_pkg.
`default_nettype none

module bpfm_frame_cell (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              sel,
   input  wire bpfm_pkg::frame_op_type            op,
   input  wire logic [bpfm_pkg::PAGE_W-1:0]       req_page,
   input  wire logic                              req_dirty,
   output bpfm_pkg::frame_view_type               view
);

   logic                          valid_ff, valid_in;
   logic [bpfm_pkg::PAGE_W-1:0]   page_ff, page_in;
   logic [bpfm_pkg::PIN_W-1:0]    pin_ff, pin_in;
   logic                          dirty_ff, dirty_in;

   always_comb begin
      valid_in = valid_ff;
      page_in  = page_ff;
      pin_in   = pin_ff;
      dirty_in = dirty_ff;
      if (sel) begin
         case (op)
            bpfm_pkg::FOP_FILL: begin
               valid_in = 1'b1;
               page_in  = req_page;
               pin_in   = bpfm_pkg::PIN_W'(1);
               dirty_in = 1'b0;
            end
            bpfm_pkg::FOP_PIN_INC: begin
               // saturate at the top
               if (pin_ff != bpfm_pkg::PIN_MAX) begin
                  pin_in = pin_ff + bpfm_pkg::PIN_W'(1);
               end
            end
            bpfm_pkg::FOP_UNPIN: begin
               pin_in   = pin_ff - bpfm_pkg::PIN_W'(1);
               dirty_in = dirty_ff | req_dirty;
            end
            bpfm_pkg::FOP_CLEAR: begin
               valid_in = 1'b0;
               page_in  = '0;
               pin_in   = '0;
               dirty_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         page_ff  <= '0;
         pin_ff   <= '0;
         dirty_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         page_ff  <= page_in;
         pin_ff   <= pin_in;
         dirty_ff <= dirty_in;
      end
   end

   assign view.valid = valid_ff;
   assign view.page  = page_ff;
   assign view.pin   = pin_ff;
   assign view.dirty = dirty_ff;
   assign view.match = valid_ff && (page_ff == req_page);

endmodule

`default_nettype wire

// File: design/bpfm_list_cell.sv
// One slot of a frame list; takes its neighbor's entry when the list closes a gap.
// No dependencies; it uses no types from bpfm_pkg.
`default_nettype none

module bpfm_list_cell #(
   parameter int IW       = 4,
   parameter int INDEX    = 0,
   parameter bit RESET_EN = 1'b0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          live,
   input  wire logic          remove_en,
   input  wire logic          write_en,
   input  wire logic [IW-1:0] write_value,
   input  wire logic [IW-1:0] probe,
   input  wire logic [IW-1:0] next_entry,
   input  wire logic          seen_in,
   output logic               seen_out,
   output logic [IW-1:0]      entry
);

   logic [IW-1:0] entry_ff, entry_in;

   // seen passes down the row: this slot or an earlier one holds the probe
   assign seen_out = seen_in | (live && (entry_ff == probe));

   always_comb begin
      entry_in = entry_ff;
      if (write_en) begin
         entry_in = write_value;
      end else if (remove_en && seen_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (RESET_EN && reset) begin
         entry_ff <= IW'(INDEX);
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// File: design/bpfm_list.sv
// Ordered frame list built as a row of list cells with a fill count.
// Depends on bpfm_pkg and bpfm_list_cell.
`default_nettype none

module bpfm_list #(
   parameter int FRAMES = bpfm_pkg::FRAMES_DEF,
   parameter bit PRESET = 1'b0
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bpfm_pkg::list_op_type             op,
   input  wire logic [$clog2(FRAMES)-1:0]         value,
   input  wire logic [$clog2(FRAMES)-1:0]         probe,
   output logic [$clog2(FRAMES+1)-1:0]            count,
   output logic [$clog2(FRAMES)-1:0]              top,
   output logic [$clog2(FRAMES)-1:0]              head,
   output logic                                   contains
);

   localparam int IW = $clog2(FRAMES);
   localparam int CW = $clog2(FRAMES+1);

   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] entry [FRAMES];
   logic [FRAMES:0] seen;
   logic [CW-1:0] top_pos;
   logic          remove_en;

   assign seen[0]   = 1'b0;
   assign remove_en = (op == bpfm_pkg::LOP_REMOVE);

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      logic [IW-1:0] nxt;
      if (i == FRAMES-1) begin : g_last
         assign nxt = entry[i];
      end else begin : g_mid
         assign nxt = entry[i+1];
      end
      bpfm_list_cell #(
         .IW       (IW),
         .INDEX    (i),
         .RESET_EN (PRESET)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .live        (count_ff > CW'(i)),
         .remove_en   (remove_en),
         .write_en    ((op == bpfm_pkg::LOP_PUSH) && (count_ff == CW'(i))),
         .write_value (value),
         .probe       (probe),
         .next_entry  (nxt),
         .seen_in     (seen[i]),
         .seen_out    (seen[i+1]),
         .entry       (entry[i])
      );
   end

   assign contains = seen[FRAMES];
   assign top_pos  = count_ff - CW'(1);
   assign top      = entry[top_pos[IW-1:0]];
   assign head     = entry[0];
   assign count    = count_ff;

   always_comb begin
      count_in = count_ff;
      case (op)
         bpfm_pkg::LOP_PUSH: begin
            if (count_ff < CW'(FRAMES)) begin
               count_in = count_ff + CW'(1);
            end
         end
         bpfm_pkg::LOP_POP: begin
            if (count_ff != '0) begin
               count_in = count_ff - CW'(1);
            end
         end
         bpfm_pkg::LOP_REMOVE: begin
            if (contains) begin
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= PRESET ? CW'(FRAMES) : '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: design/buffer_pool_frame_manager_unit.sv
// Buffer pool frame manager. Each item pins, unpins or frees one page id and
// returns exactly one result item. Every item goes through IDLE, which takes
// it, FIND for the tag match across all frame cells and lowest-index priority
// pick, DECIDE to choose the target frame (hit, free-stack top, newest hated
// frame or oldest loved frame) and APPLY to update the frame cell and the
// lists and load the result register. The loved, hated and free lists are
// rows of cells that close a gap by taking their neighbor's entry. A finished
// result waits in the output register while the next item is taken; the
// update step holds only while that register is full and stalled.
// Depends on bpfm_pkg, bpfm_frame_cell and bpfm_list.
`default_nettype none

module buffer_pool_frame_manager_unit #(
   parameter int FRAMES = bpfm_pkg::FRAMES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_kind,
   input  wire logic [bpfm_pkg::PAGE_W-1:0] req_page_id,
   input  wire logic                        req_empty_page,
   input  wire logic                        req_dirty,
   input  wire logic                        req_hate,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [2:0]                       rsp_status,
   output logic [3:0]                       rsp_frame,
   output logic                             rsp_read_needed,
   output logic                             rsp_write_back,
   output logic [bpfm_pkg::PAGE_W-1:0]      rsp_victim_page
);

   localparam int IW = $clog2(FRAMES);
   localparam int CW = $clog2(FRAMES+1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_FIND   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_APPLY  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // latched item
   bpfm_pkg::kind_type            kind_ff;
   logic [bpfm_pkg::PAGE_W-1:0]   page_ff;
   logic                          empty_ff, dirt_ff, hate_ff;

   // lookup and plan
   logic                          hit_ff, hit_in;
   logic [IW-1:0]                 f_ff, f_in;
   logic [IW-1:0]                 tgt_ff, tgt_in;
   bpfm_pkg::plan_type            plan_ff, plan_in;
   logic                          loved_has_ff;

   // result register
   logic                          rsp_valid_ff;
   bpfm_pkg::status_type          status_ff, status_in;
   logic [3:0]                    frame_ff, frame_in;
   logic                          rd_ff, rd_in, wb_ff, wb_in;
   logic [bpfm_pkg::PAGE_W-1:0]   victim_ff, victim_in;

   bpfm_pkg::frame_view_type      view [FRAMES];
   bpfm_pkg::frame_view_type      tgt_view;
   bpfm_pkg::frame_op_type        cell_op;
   bpfm_pkg::list_op_type         free_op, loved_op, hated_op;
   logic [IW-1:0]                 probe;
   logic [CW-1:0]                 free_cnt, loved_cnt, hated_cnt;
   logic [IW-1:0]                 free_top, loved_top, hated_top;
   logic [IW-1:0]                 free_head, loved_head, hated_head;
   logic                          free_has, loved_has, hated_has;
   logic                          out_free, apply_go, accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign apply_go  = (state_ff == ST_APPLY) && out_free;

   // ---------------- frame cells ----------------
   for (genvar i = 0; i < FRAMES; i++) begin : g_frame
      bpfm_frame_cell u_frame (
         .clock     (clock),
         .reset     (reset),
         .sel       (tgt_ff == IW'(i)),
         .op        (cell_op),
         .req_page  (page_ff),
         .req_dirty (dirt_ff),
         .view      (view[i])
      );
   end

   assign tgt_view = view[tgt_ff];

   // ---------------- lists ----------------
   // Probe with the looked-up frame while planning, with the target when applying.
   assign probe = (state_ff == ST_APPLY) ? tgt_ff : f_ff;

   bpfm_list #(.FRAMES(FRAMES), .PRESET(1'b1)) u_free (
      .clock (clock), .reset (reset), .op (free_op), .value (tgt_ff), .probe (probe),
      .count (free_cnt), .top (free_top), .head (free_head), .contains (free_has)
   );

   bpfm_list #(.FRAMES(FRAMES), .PRESET(1'b0)) u_loved (
      .clock (clock), .reset (reset), .op (loved_op), .value (tgt_ff), .probe (probe),
      .count (loved_cnt), .top (loved_top), .head (loved_head), .contains (loved_has)
   );

   bpfm_list #(.FRAMES(FRAMES), .PRESET(1'b0)) u_hated (
      .clock (clock), .reset (reset), .op (hated_op), .value (tgt_ff), .probe (probe),
      .count (hated_cnt), .top (hated_top), .head (hated_head), .contains (hated_has)
   );

   // ---------------- lookup: lowest matching frame ----------------
   always_comb begin
      hit_in = 1'b0;
      f_in   = '0;
      for (int i = FRAMES-1; i >= 0; i--) begin
         if (view[i].match) begin
            hit_in = 1'b1;
            f_in   = IW'(i);
         end
      end
   end

   // ---------------- plan: pick the target frame ----------------
   always_comb begin
      tgt_in  = f_ff;
      plan_in = hit_ff ? bpfm_pkg::PLAN_HIT : bpfm_pkg::PLAN_NONE;
      if (kind_ff == bpfm_pkg::KIND_PIN && !hit_ff) begin
         // free stack first, then newest hated, then oldest loved
         if (free_cnt != '0) begin
            plan_in = bpfm_pkg::PLAN_FREE;
            tgt_in  = free_top;
         end else if (hated_cnt != '0) begin
            plan_in = bpfm_pkg::PLAN_HATED;
            tgt_in  = hated_top;
         end else if (loved_cnt != '0) begin
            plan_in = bpfm_pkg::PLAN_LOVED;
            tgt_in  = loved_head;
         end
      end
   end

   // ---------------- apply: update state, form result ----------------
   always_comb begin
      cell_op   = bpfm_pkg::FOP_HOLD;
      free_op   = bpfm_pkg::LOP_HOLD;
      loved_op  = bpfm_pkg::LOP_HOLD;
      hated_op  = bpfm_pkg::LOP_HOLD;
      status_in = bpfm_pkg::STAT_OK;
      frame_in  = '0;
      rd_in     = 1'b0;
      wb_in     = 1'b0;
      victim_in = '0;
      if (apply_go) begin
         case (kind_ff)
            bpfm_pkg::KIND_PIN: begin
               if (plan_ff == bpfm_pkg::PLAN_HIT) begin
                  // a frame at zero pins sits on a list: drop it from there
                  if (tgt_view.pin == '0) begin
                     if (loved_has_ff) begin
                        loved_op = bpfm_pkg::LOP_REMOVE;
                     end else begin
                        hated_op = bpfm_pkg::LOP_REMOVE;
                     end
                  end
                  cell_op  = bpfm_pkg::FOP_PIN_INC;
                  frame_in = 4'(tgt_ff);
               end else if (plan_ff == bpfm_pkg::PLAN_NONE) begin
                  status_in = bpfm_pkg::STAT_NO_CAND;
               end else begin
                  case (plan_ff)
                     bpfm_pkg::PLAN_FREE:  free_op  = bpfm_pkg::LOP_POP;
                     bpfm_pkg::PLAN_HATED: hated_op = bpfm_pkg::LOP_POP;
                     default:              loved_op = bpfm_pkg::LOP_REMOVE;
                  endcase
                  if (tgt_view.valid && tgt_view.dirty) begin
                     wb_in     = 1'b1;
                     victim_in = tgt_view.page;
                  end
                  cell_op  = bpfm_pkg::FOP_FILL;
                  rd_in    = !empty_ff;
                  frame_in = 4'(tgt_ff);
               end
            end
            bpfm_pkg::KIND_UNPIN: begin
               if (!hit_ff) begin
                  status_in = bpfm_pkg::STAT_NOT_FOUND;
               end else begin
                  frame_in = 4'(tgt_ff);
                  if (tgt_view.pin == '0) begin
                     status_in = bpfm_pkg::STAT_ZERO_PINS;
                  end else begin
                     if (tgt_view.pin == bpfm_pkg::PIN_W'(1)) begin
                        if (hate_ff) begin
                           hated_op = bpfm_pkg::LOP_PUSH;
                        end else begin
                           loved_op = bpfm_pkg::LOP_PUSH;
                        end
                     end
                     cell_op = bpfm_pkg::FOP_UNPIN;
                  end
               end
            end
            bpfm_pkg::KIND_FREE: begin
               if (hit_ff) begin
                  frame_in = 4'(tgt_ff);
                  if (tgt_view.pin != '0) begin
                     status_in = bpfm_pkg::STAT_PINNED;
                  end else begin
                     if (loved_has_ff) begin
                        loved_op = bpfm_pkg::LOP_REMOVE;
                     end else begin
                        hated_op = bpfm_pkg::LOP_REMOVE;
                     end
                     cell_op = bpfm_pkg::FOP_CLEAR;
                     free_op = bpfm_pkg::LOP_PUSH;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_FIND;
         ST_FIND:   state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_APPLY;
         ST_APPLY:  if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (apply_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold item, lookup, plan and result registers between steps
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= bpfm_pkg::kind_type'(req_kind);
         page_ff  <= req_page_id;
         empty_ff <= req_empty_page;
         dirt_ff  <= req_dirty;
         hate_ff  <= req_hate;
      end
      if (state_ff == ST_FIND) begin
         hit_ff <= hit_in;
         f_ff   <= f_in;
      end
      if (state_ff == ST_DECIDE) begin
         tgt_ff       <= tgt_in;
         plan_ff      <= plan_in;
         loved_has_ff <= loved_has;
      end
      if (apply_go) begin
         status_ff <= status_in;
         frame_ff  <= frame_in;
         rd_ff     <= rd_in;
         wb_ff     <= wb_in;
         victim_ff <= victim_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_frame       = frame_ff;
   assign rsp_read_needed = rd_ff;
   assign rsp_write_back  = wb_ff;
   assign rsp_victim_page = victim_ff;

endmodule

`default_nettype wire

// File: design/bpfm_checker.sv
// Port-level checks for the buffer pool frame manager, bound to the top level.
// Depends on bpfm_pkg and buffer_pool_frame_manager_unit.
`default_nettype none

module bpfm_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [2:0]                  rsp_status,
   input wire logic                        rsp_read_needed,
   input wire logic                        rsp_write_back,
   input wire logic [bpfm_pkg::PAGE_W-1:0] rsp_victim_page
);

   // an item is worked on until APPLY finishes: no back-to-back acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken in the cycle after an accept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_victim_page))
      else $error("stalled result changed");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bpfm_pkg::STAT_OK |->
         !rsp_read_needed && !rsp_write_back && rsp_victim_page == '0)
      else $error("failed item reports a transfer");

   a_victim_only_on_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_back |-> rsp_victim_page == '0)
      else $error("victim page without write-back");

endmodule

bind buffer_pool_frame_manager_unit bpfm_checker u_bpfm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_read_needed (rsp_read_needed),
   .rsp_write_back  (rsp_write_back),
   .rsp_victim_page (rsp_victim_page)
);

`default_nettype wire

// File: tb/tb_buffer_pool_frame_manager_unit.sv
// Self-checking testbench for the buffer pool frame manager: drives pin, unpin,
// free and unknown-kind items, predicts each result in a local frame-table model and checks.
// Depends on bpfm_pkg and buffer_pool_frame_manager_unit.
`timescale 1ns / 100ps

module tb_buffer_pool_frame_manager_unit;

   localparam int NF = 16;
   localparam int WATCH_LIMIT = 20000;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic [1:0]  kind;
      logic [30:0] page;
      logic        empty_page;
      logic        dirty;
      logic        hate;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  frame;
      logic        read_needed;
      logic        write_back;
      logic [30:0] victim;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_kind = '0;
   logic [30:0] req_page_id = '0;
   logic req_empty_page = 1'b0;
   logic req_dirty = 1'b0;
   logic req_hate = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [3:0] rsp_frame;
   logic rsp_read_needed;
   logic rsp_write_back;
   logic [30:0] rsp_victim_page;

   buffer_pool_frame_manager_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_page_id(req_page_id), .req_empty_page(req_empty_page),
      .req_dirty(req_dirty), .req_hate(req_hate),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_frame(rsp_frame), .rsp_read_needed(rsp_read_needed),
      .rsp_write_back(rsp_write_back), .rsp_victim_page(rsp_victim_page)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Frame table mirror
   logic [30:0] fr_page [NF];
   logic        fr_valid [NF];
   logic [7:0]  fr_pins [NF];
   logic        fr_dirty [NF];
   int          loved_q [$];
   int          hated_q [$];
   int          free_q [$];

   cmd_type    pending_cmds [$];
   answer_type expected_answers [$];

   int sender_idle_pct = 0;
   int stall_pct = 0;
   bit hold_start = 1'b0;
   int hold_left = 0;
   int mismatches = 0;
   int accepted_cmds = 0;
   int checked_answers = 0;
   int evictions = 0;
   int idle_cycles = 0;
   bit timed_out = 1'b0;

   function automatic int lookup(input logic [30:0] page);
      for (int i = 0; i < NF; i++)
         if (fr_valid[i] && fr_page[i] == page) return i;
      return -1;
   endfunction

   // Drop frame f from loved list, else from hated list
   function automatic void unqueue(input int f);
      foreach (loved_q[i])
         if (loved_q[i] == f) begin
            loved_q.delete(i);
            return;
         end
      foreach (hated_q[i])
         if (hated_q[i] == f) begin
            hated_q.delete(i);
            return;
         end
   endfunction

   function automatic answer_type apply_cmd(input cmd_type c);
      answer_type a;
      int f;
      a = '0;
      f = lookup(c.page);
      case (c.kind)
         bpfm_pkg::KIND_PIN: begin
            if (f >= 0) begin
               if (fr_pins[f] == 0) unqueue(f);
               if (fr_pins[f] != bpfm_pkg::PIN_MAX) fr_pins[f]++;
               a.frame = f[3:0];
            end else begin
               if (free_q.size() > 0) begin
                  f = free_q[$];
                  free_q.delete(free_q.size() - 1);
               end else if (hated_q.size() > 0) begin
                  f = hated_q[$];
                  hated_q.delete(hated_q.size() - 1);
               end else if (loved_q.size() > 0) begin
                  f = loved_q[0];
                  loved_q.delete(0);
               end
               if (f < 0) begin
                  a.status = bpfm_pkg::STAT_NO_CAND;
               end else begin
                  if (fr_valid[f] && fr_dirty[f]) begin
                     a.write_back = 1'b1;
                     a.victim = fr_page[f];
                  end
                  if (fr_valid[f]) evictions++;
                  fr_page[f] = c.page;
                  fr_valid[f] = 1'b1;
                  fr_dirty[f] = 1'b0;
                  fr_pins[f] = 8'd1;
                  a.read_needed = !c.empty_page;
                  a.frame = f[3:0];
               end
            end
         end
         bpfm_pkg::KIND_UNPIN: begin
            if (f < 0) begin
               a.status = bpfm_pkg::STAT_NOT_FOUND;
            end else begin
               a.frame = f[3:0];
               if (fr_pins[f] == 0) begin
                  a.status = bpfm_pkg::STAT_ZERO_PINS;
               end else begin
                  if (fr_pins[f] == 1) begin
                     if (c.hate) hated_q.insert(hated_q.size(), f);
                     else loved_q.insert(loved_q.size(), f);
                  end
                  fr_pins[f]--;
                  fr_dirty[f] |= c.dirty;
               end
            end
         end
         bpfm_pkg::KIND_FREE: begin
            if (f >= 0) begin
               a.frame = f[3:0];
               if (fr_pins[f] != 0) begin
                  a.status = bpfm_pkg::STAT_PINNED;
               end else begin
                  unqueue(f);
                  fr_valid[f] = 1'b0;
                  fr_page[f] = '0;
                  fr_dirty[f] = 1'b0;
                  if (free_q.size() < NF) free_q.insert(free_q.size(), f);
               end
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic cmd_type make_cmd(input logic [1:0] k, input logic [30:0] p,
                                        input logic e, input logic d, input logic h);
      cmd_type c;
      c.kind = k;
      c.page = p;
      c.empty_page = e;
      c.dirty = d;
      c.hate = h;
      return c;
   endfunction

   // Mostly pages from a small working set so hits, evictions and errors occur
   function automatic logic [30:0] pick_page();
      case ($urandom_range(0, 9))
         0: return 31'($urandom());
         1: return 31'(32'h7FFF_FFFF - $urandom_range(0, 3));
         default: return 31'(32'h5555_0000 + $urandom_range(0, 23));
      endcase
   endfunction

   function automatic cmd_type rand_cmd();
      int r;
      logic [1:0] k;
      r = $urandom_range(0, 99);
      if (r < 45) k = bpfm_pkg::KIND_PIN;
      else if (r < 85) k = bpfm_pkg::KIND_UNPIN;
      else if (r < 97) k = bpfm_pkg::KIND_FREE;
      else k = bpfm_pkg::KIND_NONE;
      return make_cmd(k, pick_page(), 1'($urandom()), 1'($urandom()), 1'($urandom()));
   endfunction

   // Driver: advance on accept, hold payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            cmd_type c;
            c = pending_cmds[0];
            pending_cmds.delete(0);
            req_valid <= 1'b1;
            req_kind <= c.kind;
            req_page_id <= c.page;
            req_empty_page <= c.empty_page;
            req_dirty <= c.dirty;
            req_hate <= c.hate;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Predict on accept
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_answers.insert(expected_answers.size(),
                                 apply_cmd(make_cmd(req_kind, req_page_id,
                                           req_empty_page, req_dirty, req_hate)));
         accepted_cmds++;
      end
   end

   // Receiver stall; a requested hold-off is counted down here
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_start) begin
         hold_start = 1'b0;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         answer_type got, want;
         got.status = rsp_status;
         got.frame = rsp_frame;
         got.read_needed = rsp_read_needed;
         got.write_back = rsp_write_back;
         got.victim = rsp_victim_page;
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result status=%0d frame=%0d", got.status,
                        got.frame);
         end else begin
            want = expected_answers[0];
            expected_answers.delete(0);
            checked_answers++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"ERROR: result %0d exp st=%0d fr=%0d rd=%0b wb=%0b vp=%h",
                            " got st=%0d fr=%0d rd=%0b wb=%0b vp=%h"}, checked_answers,
                           want.status, want.frame, want.read_needed, want.write_back,
                           want.victim, got.status, got.frame, got.read_needed,
                           got.write_back, got.victim);
            end
         end
      end
   end

   // Watchdog: cycles with no accept on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog expired, %0d results still expected", expected_answers.size());
         $display("buffer_pool_frame_manager_unit test failed");
         $finish;
      end
   end

   task automatic drain();
      while (pending_cmds.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_p, input int n);
      sender_idle_pct = idle_pct;
      stall_pct = stall_p;
      for (int i = 0; i < n; i++) pending_cmds.insert(pending_cmds.size(), rand_cmd());
      drain();
   endtask

   task automatic add_cmd(input cmd_type c);
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   initial begin
      for (int i = 0; i < NF; i++) begin
         fr_page[i] = '0;
         fr_valid[i] = 1'b0;
         fr_pins[i] = '0;
         fr_dirty[i] = 1'b0;
         free_q.insert(free_q.size(), i);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: unknown kind, misses, extremes, errors, fill and evict
      add_cmd(make_cmd(bpfm_pkg::KIND_NONE, 31'h7FFF_FFFF, 1'b1, 1'b1, 1'b1));
      add_cmd(make_cmd(bpfm_pkg::KIND_UNPIN, 31'd0, 1'b0, 1'b1, 1'b1));
      add_cmd(make_cmd(bpfm_pkg::KIND_FREE, 31'd0, 1'b0, 1'b0, 1'b0));
      add_cmd(make_cmd(bpfm_pkg::KIND_PIN, 31'd0, 1'b0, 1'b0, 1'b0));
      add_cmd(make_cmd(bpfm_pkg::KIND_PIN, 31'h7FFF_FFFF, 1'b1, 1'b0, 1'b0));
      add_cmd(make_cmd(bpfm_pkg::KIND_FREE, 31'd0, 1'b0, 1'b0, 1'b0));
      add_cmd(make_cmd(bpfm_pkg::KIND_UNPIN, 31'd0, 1'b0, 1'b1, 1'b0));
      add_cmd(make_cmd(bpfm_pkg::KIND_UNPIN, 31'd0, 1'b0, 1'b0, 1'b0));
      add_cmd(make_cmd(bpfm_pkg::KIND_UNPIN, 31'h7FFF_FFFF, 1'b0, 1'b1, 1'b1));
      add_cmd(make_cmd(bpfm_pkg::KIND_FREE, 31'd0, 1'b0, 1'b0, 1'b0));
      for (int i = 1; i <= 16; i++)
         add_cmd(make_cmd(bpfm_pkg::KIND_PIN, 31'(32'h100 + i), i[0], 1'b0, 1'b0));
      add_cmd(make_cmd(bpfm_pkg::KIND_PIN, 31'h200, 1'b0, 1'b0, 1'b0));
      drain();

      run_phase(0, 0, 70);
      run_phase(81, 0, 70);
      run_phase(0, 81, 70);
      run_phase(12, 12, 70);

      // Long hold-off so the block backs up and stalls its input
      sender_idle_pct = 0;
      stall_pct = 0;
      hold_start = 1'b1;
      for (int i = 0; i < 40; i++) pending_cmds.insert(pending_cmds.size(), rand_cmd());
      drain();
      run_phase(0, 0, 50);

      $display("covered %0d items, %0d results checked, %0d evictions of live frames",
               accepted_cmds, checked_answers, evictions);
      if (mismatches == 0)
         $display("buffer_pool_frame_manager_unit test passed");
      else
         $display("buffer_pool_frame_manager_unit test failed");
      $finish;
   end

endmodule
